// File: rtl/avg_pkg.sv
package avg_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int IDX_W   = 9;
    localparam int ANG_W   = 16;
    localparam int COORD_W = 15;
    localparam int CNT_W   = 9;
    localparam int MAG_W   = 14;
    localparam int CFG_AW  = 2;

    // clamped sweep magnitude, degree count, sweep * index
    localparam int SWP_W  = 15;
    localparam int DEG_W  = 9;
    localparam int DPR_W  = 22;
    localparam int DPROD_W = SWP_W + DPR_W;
    localparam int PROD_W = 24;
    localparam int DIVD_W = PROD_W + 16;

    // long division: 31 quotient bits, four per stage
    localparam int QUO_W      = 31;
    localparam int REM_W      = DEG_W + 1;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;

    // CORDIC datapath (Q30 x/y, Q28 z)
    localparam int CW    = 32;
    localparam int FOLD_W = 33;

    localparam logic [SWP_W-1:0] SWEEP_FULL  = 15'd25736;
    localparam logic [DPR_W-1:0] DEG_PER_RAD = 22'd3754936;

    localparam logic signed [FOLD_W-1:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [FOLD_W-1:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [FOLD_W-1:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [CW-1:0]     START_X_Q30 = 32'sd326016437;
    localparam logic [MAG_W-1:0]         OUT_LIMIT   = 14'd8192;

    localparam logic [CFG_AW-1:0] REG_ARC_ANGLE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MIRROR_X  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MIRROR_Y  = 2'd2;

    typedef struct packed {
        logic             present;
        logic [CNT_W-1:0] count;
        logic             mirror_x;
        logic             mirror_y;
    } side_t;

    function automatic logic [27:0] atan_q28(input int i);
        logic [27:0] v;
        case (i)
            0:  v = 28'd210828714;
            1:  v = 28'd124459457;
            2:  v = 28'd65760959;
            3:  v = 28'd33381290;
            4:  v = 28'd16755422;
            5:  v = 28'd8385879;
            6:  v = 28'd4193963;
            7:  v = 28'd2097109;
            8:  v = 28'd1048571;
            9:  v = 28'd524287;
            10: v = 28'd262144;
            11: v = 28'd131072;
            12: v = 28'd65536;
            13: v = 28'd32768;
            14: v = 28'd16384;
            15: v = 28'd8192;
            16: v = 28'd4096;
            17: v = 28'd2048;
            18: v = 28'd1024;
            19: v = 28'd512;
            20: v = 28'd256;
            21: v = 28'd128;
            22: v = 28'd64;
            23: v = 28'd32;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/avg_div.sv
module avg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  avg_pkg::side_t                 in_side,
    input  logic [avg_pkg::DIVD_W-1:0]     dividend,
    input  logic [avg_pkg::DEG_W-1:0]      divisor,
    output logic                           out_valid,
    output avg_pkg::side_t                 out_side,
    output logic [avg_pkg::QUO_W-1:0]      quotient
);
    import avg_pkg::*;

    logic               val [0:DIV_STAGES];
    side_t              sd  [0:DIV_STAGES];
    logic [REM_W-1:0]   rem [0:DIV_STAGES];
    logic [QUO_W-1:0]   low [0:DIV_STAGES];
    logic [QUO_W-1:0]   quo [0:DIV_STAGES];
    logic [DEG_W-1:0]   dv  [0:DIV_STAGES];

    // remainder starts with the bits above the quotient field
    assign val[0] = in_valid;
    assign sd[0]  = in_side;
    assign rem[0] = {1'b0, dividend[DIVD_W-1:QUO_W]};
    assign low[0] = dividend[QUO_W-1:0];
    assign quo[0] = '0;
    assign dv[0]  = divisor;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [REM_W-1:0] r_c;
        logic [QUO_W-1:0] l_c;
        logic [QUO_W-1:0] q_c;
        logic [REM_W-1:0] d_c;

        always_comb
        begin
            r_c = rem[s];
            l_c = low[s];
            q_c = quo[s];
            d_c = {1'b0, dv[s]};
            for (int k = 0; k < DIV_STEP; k++)
            begin
                if (s * DIV_STEP + k < QUO_W)
                begin
                    r_c = {r_c[REM_W-2:0], l_c[QUO_W-1]};
                    l_c = {l_c[QUO_W-2:0], 1'b0};
                    if (r_c >= d_c)
                    begin
                        r_c = r_c - d_c;
                        q_c = {q_c[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_c = {q_c[QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val[s+1] <= 1'b0;
            else
                val[s+1] <= val[s];
        end

        always_ff @(posedge clk)
        begin
            sd[s+1]  <= sd[s];
            rem[s+1] <= r_c;
            low[s+1] <= l_c;
            quo[s+1] <= q_c;
            dv[s+1]  <= dv[s];
        end
    end

    assign out_valid = val[DIV_STAGES];
    assign out_side  = sd[DIV_STAGES];
    assign quotient  = quo[DIV_STAGES];

endmodule

// File: rtl/avg_cordic.sv
module avg_cordic #(
    parameter int STAGES = avg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  avg_pkg::side_t                in_side,
    input  logic [avg_pkg::QUO_W-1:0]     theta,
    output logic                          out_valid,
    output avg_pkg::side_t                out_side,
    output logic [avg_pkg::MAG_W-1:0]     x_mag,
    output logic                          x_neg,
    output logic [avg_pkg::MAG_W-1:0]     y_mag,
    output logic                          y_neg
);
    import avg_pkg::*;

    localparam int RND_W = CW - 16 + 1;

    logic                 val [0:STAGES];
    side_t                sd  [0:STAGES];
    logic                 fl  [0:STAGES];
    logic signed [CW-1:0] xr  [0:STAGES];
    logic signed [CW-1:0] yr  [0:STAGES];
    logic signed [CW-1:0] zr  [0:STAGES];

    // fold into -pi/2..pi/2; a fold by pi flips both signs
    logic signed [FOLD_W-1:0] t0_c, t1_c, t2_c;
    logic                     fold_c;

    always_comb
    begin
        t0_c   = $signed({2'b00, theta});
        t1_c   = (t0_c > PI_Q28) ? t0_c - TWO_PI_Q28 : t0_c;
        t2_c   = t1_c;
        fold_c = 1'b0;
        if (t1_c > HALF_PI_Q28)
        begin
            t2_c   = t1_c - PI_Q28;
            fold_c = 1'b1;
        end
        else if (t1_c < -HALF_PI_Q28)
        begin
            t2_c   = t1_c + PI_Q28;
            fold_c = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val[0] <= 1'b0;
        else
            val[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        sd[0] <= in_side;
        fl[0] <= fold_c;
        xr[0] <= START_X_Q30;
        yr[0] <= '0;
        zr[0] <= t2_c[CW-1:0];
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [CW-1:0] dx_c, dy_c, at_c;

        assign dx_c = yr[i] >>> i;
        assign dy_c = xr[i] >>> i;
        assign at_c = $signed({{(CW-28){1'b0}}, atan_q28(i)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val[i+1] <= 1'b0;
            else
                val[i+1] <= val[i];
        end

        always_ff @(posedge clk)
        begin
            sd[i+1] <= sd[i];
            fl[i+1] <= fl[i];
            if (!zr[i][CW-1])
            begin
                xr[i+1] <= xr[i] - dx_c;
                yr[i+1] <= yr[i] + dy_c;
                zr[i+1] <= zr[i] - at_c;
            end
            else
            begin
                xr[i+1] <= xr[i] + dx_c;
                yr[i+1] <= yr[i] - dy_c;
                zr[i+1] <= zr[i] + at_c;
            end
        end
    end

    // Q30 -> Q14 magnitude, round half away from zero, saturate
    logic [CW-1:0]    xa_c, ya_c;
    logic [RND_W-1:0] xrn_c, yrn_c;
    logic [MAG_W-1:0] xm_c, ym_c;

    always_comb
    begin
        xa_c  = xr[STAGES][CW-1] ? CW'(-xr[STAGES]) : CW'(xr[STAGES]);
        ya_c  = yr[STAGES][CW-1] ? CW'(-yr[STAGES]) : CW'(yr[STAGES]);
        xrn_c = RND_W'(({1'b0, xa_c} + (CW+1)'(32768)) >> 16);
        yrn_c = RND_W'(({1'b0, ya_c} + (CW+1)'(32768)) >> 16);
        xm_c  = (xrn_c > RND_W'(OUT_LIMIT)) ? OUT_LIMIT : xrn_c[MAG_W-1:0];
        ym_c  = (yrn_c > RND_W'(OUT_LIMIT)) ? OUT_LIMIT : yrn_c[MAG_W-1:0];
    end

    logic  ov_reg;
    side_t os_reg;
    logic [MAG_W-1:0] xm_reg, ym_reg;
    logic  xn_reg, yn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= val[STAGES];
    end

    always_ff @(posedge clk)
    begin
        os_reg <= sd[STAGES];
        xm_reg <= xm_c;
        ym_reg <= ym_c;
        xn_reg <= xr[STAGES][CW-1] ^ fl[STAGES] ^ sd[STAGES].mirror_x;
        yn_reg <= yr[STAGES][CW-1] ^ fl[STAGES] ^ sd[STAGES].mirror_y;
    end

    assign out_valid = ov_reg;
    assign out_side  = os_reg;
    assign x_mag     = xm_reg;
    assign x_neg     = xn_reg;
    assign y_mag     = ym_reg;
    assign y_neg     = yn_reg;

endmodule

// File: rtl/arc_vertex_generator.sv
// Arc vertex generator: one point of a radius-0.5 arc per transaction.
// Pipeline from start to done:
//   2 front stages, 8 long-division stages, fold + one stage per CORDIC
//   iteration + rounding, and the output register.
// Throughput: one transaction per cycle; busy is never raised, receiver cannot stall.
// Reset (rst_n low, async): pipeline emptied, arc_angle/mirror_x/mirror_y cleared.
module arc_vertex_generator #(
    parameter int CORDIC_STAGES = avg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [avg_pkg::IDX_W-1:0]           point_index,
    input  logic                                cfg_we,
    input  logic [avg_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [avg_pkg::ANG_W-1:0]           cfg_wdata,
    output logic                                done,
    output logic signed [avg_pkg::COORD_W-1:0]  x_coord,
    output logic signed [avg_pkg::COORD_W-1:0]  y_coord,
    output logic [avg_pkg::CNT_W-1:0]           point_count,
    output logic                                point_present
);
    import avg_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [ANG_W-1:0] arc_angle_reg;
    logic                    mirror_x_reg;
    logic                    mirror_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_angle_reg <= '0;
            mirror_x_reg  <= 1'b0;
            mirror_y_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ARC_ANGLE: arc_angle_reg <= cfg_wdata;
                REG_MIRROR_X:  mirror_x_reg  <= cfg_wdata[0];
                REG_MIRROR_Y:  mirror_y_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // every cycle can take a transaction
    assign busy = 1'b0;

    // ---------------- stage 0: clamp sweep to 0..2pi ----------------
    logic signed [ANG_W:0] ang_ext_c, ang_clamp_c;
    logic signed [ANG_W:0] full_c;

    always_comb
    begin
        full_c    = $signed({2'b00, SWEEP_FULL});
        ang_ext_c = {arc_angle_reg[ANG_W-1], arc_angle_reg};
        if (ang_ext_c > full_c)
            ang_clamp_c = full_c;
        else if (ang_ext_c < -full_c)
            ang_clamp_c = -full_c;
        else
            ang_clamp_c = ang_ext_c;
        if (ang_clamp_c[ANG_W])
            ang_clamp_c = ang_clamp_c + full_c;
    end

    logic             v0_reg;
    logic [SWP_W-1:0] ang0_reg;
    logic [IDX_W-1:0] idx0_reg;
    logic             mx0_reg, my0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ang0_reg <= ang_clamp_c[SWP_W-1:0];
        idx0_reg <= point_index;
        mx0_reg  <= mirror_x_reg;
        my0_reg  <= mirror_y_reg;
    end

    // ---------------- stage 1: degree count and sweep * index ----------------
    logic [DPROD_W-1:0] deg_prod_c;
    assign deg_prod_c = DPROD_W'(ang0_reg) * DPROD_W'(DEG_PER_RAD);

    logic              v1_reg;
    logic [DEG_W-1:0]  deg1_reg;
    logic [PROD_W-1:0] prod1_reg;
    logic [IDX_W-1:0]  idx1_reg;
    logic              mx1_reg, my1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        deg1_reg  <= deg_prod_c[DPROD_W-1:28];
        prod1_reg <= PROD_W'(ang0_reg) * PROD_W'(idx0_reg);
        idx1_reg  <= idx0_reg;
        mx1_reg   <= mx0_reg;
        my1_reg   <= my0_reg;
    end

    // ---------------- divider: theta = (sweep*index << 16) / deg ----------------
    side_t            side_in_c;
    logic [DEG_W-1:0] divisor_c;

    always_comb
    begin
        side_in_c.present  = (deg1_reg != '0) && (idx1_reg <= deg1_reg);
        side_in_c.count    = deg1_reg + CNT_W'(1);
        side_in_c.mirror_x = mx1_reg;
        side_in_c.mirror_y = my1_reg;
        // zero degrees means no point; keep the divider away from zero
        divisor_c = (deg1_reg == '0) ? DEG_W'(1) : deg1_reg;
    end

    logic             div_valid;
    side_t            div_side;
    logic [QUO_W-1:0] div_quo;

    avg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_side   (side_in_c),
        .dividend  ({prod1_reg, 16'b0}),
        .divisor   (divisor_c),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quotient  (div_quo)
    );

    // ---------------- CORDIC rotation ----------------
    logic             cor_valid;
    side_t            cor_side;
    logic [MAG_W-1:0] cor_xm, cor_ym;
    logic             cor_xn, cor_yn;

    avg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_side   (div_side),
        .theta     (div_quo),
        .out_valid (cor_valid),
        .out_side  (cor_side),
        .x_mag     (cor_xm),
        .x_neg     (cor_xn),
        .y_mag     (cor_ym),
        .y_neg     (cor_yn)
    );

    // ---------------- output register: apply signs, blank absent points ----------------
    logic signed [COORD_W-1:0] x_next, y_next;

    always_comb
    begin
        x_next = '0;
        y_next = '0;
        if (cor_side.present)
        begin
            x_next = cor_xn ? -$signed({1'b0, cor_xm}) : $signed({1'b0, cor_xm});
            y_next = cor_yn ? -$signed({1'b0, cor_ym}) : $signed({1'b0, cor_ym});
        end
    end

    logic                      done_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cor_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        count_reg   <= cor_side.count;
        present_reg <= cor_side.present;
    end

    assign done          = done_reg;
    assign x_coord       = x_reg;
    assign y_coord       = y_reg;
    assign point_count   = count_reg;
    assign point_present = present_reg;

`ifndef SYNTHESIS
    // a present point needs at least two points on the arc
    a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && point_present) |-> (point_count > CNT_W'(1)))
        else $error("point present with count below two");

    // absent points come out at the origin
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !point_present) |-> (x_coord == '0 && y_coord == '0))
        else $error("absent point has nonzero coordinates");

    // coordinates stay inside the saturation range
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (x_coord >= -15'sd8192 && x_coord <= 15'sd8192
                  && y_coord >= -15'sd8192 && y_coord <= 15'sd8192))
        else $error("coordinate outside saturation range");
`endif

endmodule
